// ===== sv/rep_pkg.sv =====
`timescale 1ns / 1ps

package rep_pkg;

    // Iteration count defaults and table size
    localparam int unsigned CORDIC_STAGES_DEF = 16;
    localparam int unsigned ATAN_ENTRIES      = 24;

    // CORDIC vector and angle widths
    localparam int unsigned CW = 34;
    localparam int unsigned ZW = 34;

    // Start vector x: gain constant in Q2.30
    localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sd652032874;

    // Configuration port
    localparam int unsigned WR_INDEX_W = 3;
    localparam int unsigned WR_DATA_W  = 32;

    localparam logic [WR_INDEX_W-1:0] REG_CENTER_X     = 3'd0;
    localparam logic [WR_INDEX_W-1:0] REG_CENTER_Y     = 3'd1;
    localparam logic [WR_INDEX_W-1:0] REG_MAJOR_RADIUS = 3'd2;
    localparam logic [WR_INDEX_W-1:0] REG_MINOR_RADIUS = 3'd3;
    localparam logic [WR_INDEX_W-1:0] REG_ROTATION     = 3'd4;

    // atan(2^-i) in units of 2^-32 turn
    function automatic logic [31:0] atan_turn(input int unsigned idx);
        logic [31:0] val;
        unique case (idx)
            0:       val = 32'h20000000;
            1:       val = 32'h12E4051E;
            2:       val = 32'h09FB385B;
            3:       val = 32'h051111D4;
            4:       val = 32'h028B0D43;
            5:       val = 32'h0145D7E1;
            6:       val = 32'h00A2F61E;
            7:       val = 32'h00517C55;
            8:       val = 32'h0028BE53;
            9:       val = 32'h00145F2F;
            10:      val = 32'h000A2F98;
            11:      val = 32'h000517CC;
            12:      val = 32'h00028BE6;
            13:      val = 32'h000145F3;
            14:      val = 32'h0000A2FA;
            15:      val = 32'h0000517D;
            16:      val = 32'h000028BE;
            17:      val = 32'h0000145F;
            18:      val = 32'h00000A30;
            19:      val = 32'h00000518;
            20:      val = 32'h0000028C;
            21:      val = 32'h00000146;
            22:      val = 32'h000000A3;
            23:      val = 32'h00000051;
            default: val = 32'h00000000;
        endcase
        return val;
    endfunction

endpackage

// ===== sv/rep_cordic.sv =====
`timescale 1ns / 1ps

// Pipelined rotation-mode CORDIC: 16-bit turn fraction in, cos/sin in Q2.30 out.
// Registered steps in order: input capture, ITERS iteration stages, quadrant fold.
module rep_cordic #(
    parameter int unsigned ITERS = rep_pkg::CORDIC_STAGES_DEF
) (
    input  logic                            clk,
    input  logic [15:0]                     ang,
    output logic signed [rep_pkg::CW-1:0]   cos_val,
    output logic signed [rep_pkg::CW-1:0]   sin_val
);

    localparam int unsigned CW = rep_pkg::CW;
    localparam int unsigned ZW = rep_pkg::ZW;

    logic signed [CW-1:0] x_reg [0:ITERS];
    logic signed [CW-1:0] y_reg [0:ITERS];
    logic signed [ZW-1:0] z_reg [0:ITERS];
    logic [1:0]           q_reg [0:ITERS];

    logic signed [CW-1:0] cos_next;
    logic signed [CW-1:0] sin_next;
    logic signed [CW-1:0] cos_reg;
    logic signed [CW-1:0] sin_reg;

    // Capture: quadrant off the top, low 14 bits into the turn accumulator
    always_ff @(posedge clk)
    begin
        x_reg[0] <= rep_pkg::CORDIC_GAIN;
        y_reg[0] <= '0;
        z_reg[0] <= $signed({4'b0000, ang[13:0], 16'h0000});
        q_reg[0] <= ang[15:14];
    end

    // One micro-rotation per stage
    for (genvar i = 0; i < ITERS; i++)
    begin : g_iter
        localparam logic signed [ZW-1:0] ATAN =
            $signed({2'b00, rep_pkg::atan_turn(i)});

        logic signed [CW-1:0] dx;
        logic signed [CW-1:0] dy;
        logic signed [CW-1:0] x_next;
        logic signed [CW-1:0] y_next;
        logic signed [ZW-1:0] z_next;

        always_comb
        begin
            dx = y_reg[i] >>> i;
            dy = x_reg[i] >>> i;
            if (!z_reg[i][ZW-1])
            begin
                x_next = x_reg[i] - dx;
                y_next = y_reg[i] + dy;
                z_next = z_reg[i] - ATAN;
            end
            else
            begin
                x_next = x_reg[i] + dx;
                y_next = y_reg[i] - dy;
                z_next = z_reg[i] + ATAN;
            end
        end

        always_ff @(posedge clk)
        begin
            x_reg[i+1] <= x_next;
            y_reg[i+1] <= y_next;
            z_reg[i+1] <= z_next;
            q_reg[i+1] <= q_reg[i];
        end
    end

    // Quadrant fold
    always_comb
    begin
        unique case (q_reg[ITERS])
            2'd0:
            begin
                cos_next = x_reg[ITERS];
                sin_next = y_reg[ITERS];
            end
            2'd1:
            begin
                cos_next = -y_reg[ITERS];
                sin_next = x_reg[ITERS];
            end
            2'd2:
            begin
                cos_next = -x_reg[ITERS];
                sin_next = -y_reg[ITERS];
            end
            2'd3:
            begin
                cos_next = y_reg[ITERS];
                sin_next = -x_reg[ITERS];
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        cos_reg <= cos_next;
        sin_reg <= sin_next;
    end

    assign cos_val = cos_reg;
    assign sin_val = sin_reg;

endmodule

// ===== sv/rotated_ellipse_point.sv =====
`timescale 1ns / 1ps
// A beat's result reaches point_x/point_y with done after the CORDIC capture,
//   iteration, fold, scale, round, rotate, combine and output registers.
// Throughput: one beat per cycle; busy stays low, start may be held high every cycle.
// Results are held for exactly one cycle; the receiver cannot stall the pipeline.
// Reset (rst_n low, async): pipeline valids clear, configuration registers return to their defaults.
module rotated_ellipse_point #(
    parameter int unsigned CORDIC_STAGES = rep_pkg::CORDIC_STAGES_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [15:0]                         angle,
    output logic                                done,
    output logic signed [31:0]                  point_x,
    output logic signed [31:0]                  point_y,
    input  logic                                wr_en,
    input  logic [rep_pkg::WR_INDEX_W-1:0]      wr_index,
    input  logic [rep_pkg::WR_DATA_W-1:0]       wr_data
);

    localparam int unsigned ITERS = (CORDIC_STAGES < rep_pkg::ATAN_ENTRIES) ?
                                    CORDIC_STAGES : rep_pkg::ATAN_ENTRIES;
    localparam int unsigned CW  = rep_pkg::CW;
    localparam int unsigned LAT = ITERS + 7;

    localparam logic signed [65:0] RND_66  = 66'sd536870912;
    localparam logic signed [68:0] RND_69  = 69'sd536870912;
    localparam logic signed [36:0] SAT_MAX = 37'sd2147483647;
    localparam logic signed [36:0] SAT_MIN = -37'sd2147483648;

    // Configuration registers
    logic signed [31:0] center_x_reg;
    logic signed [31:0] center_y_reg;
    logic [30:0]        major_radius_reg;
    logic [30:0]        minor_radius_reg;
    logic [15:0]        rotation_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_x_reg     <= '0;
            center_y_reg     <= '0;
            major_radius_reg <= 31'd131072;
            minor_radius_reg <= 31'd65536;
            rotation_reg     <= '0;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                rep_pkg::REG_CENTER_X:     center_x_reg     <= $signed(wr_data);
                rep_pkg::REG_CENTER_Y:     center_y_reg     <= $signed(wr_data);
                rep_pkg::REG_MAJOR_RADIUS: major_radius_reg <= wr_data[30:0];
                rep_pkg::REG_MINOR_RADIUS: minor_radius_reg <= wr_data[30:0];
                rep_pkg::REG_ROTATION:     rotation_reg     <= wr_data[15:0];
                default:                   ;
            endcase
        end
    end

    // Beat valids, one per pipeline stage
    logic vld_reg [0:LAT-1];

    assign busy = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < LAT; k++)
            begin
                vld_reg[k] <= 1'b0;
            end
        end
        else
        begin
            vld_reg[0] <= start & ~busy;
            for (int k = 1; k < LAT; k++)
            begin
                vld_reg[k] <= vld_reg[k-1];
            end
        end
    end

    // Sine/cosine of the parameter angle and of the rotation, side by side
    logic signed [CW-1:0] cos_t;
    logic signed [CW-1:0] sin_t;
    logic signed [CW-1:0] cos_r;
    logic signed [CW-1:0] sin_r;

    rep_cordic #(
        .ITERS (ITERS)
    ) u_cordic_t (
        .clk     (clk),
        .ang     (angle),
        .cos_val (cos_t),
        .sin_val (sin_t)
    );

    rep_cordic #(
        .ITERS (ITERS)
    ) u_cordic_r (
        .clk     (clk),
        .ang     (rotation_reg),
        .cos_val (cos_r),
        .sin_val (sin_r)
    );

    // Scale by the radii
    logic signed [31:0]   a_s;
    logic signed [31:0]   b_s;
    logic signed [65:0]   prod_x_next;
    logic signed [65:0]   prod_y_next;
    logic signed [65:0]   prod_x_reg;
    logic signed [65:0]   prod_y_reg;
    logic signed [CW-1:0] cr_d1_reg;
    logic signed [CW-1:0] sr_d1_reg;

    assign a_s         = $signed({1'b0, major_radius_reg});
    assign b_s         = $signed({1'b0, minor_radius_reg});
    assign prod_x_next = a_s * cos_t;
    assign prod_y_next = b_s * sin_t;

    always_ff @(posedge clk)
    begin
        prod_x_reg <= prod_x_next;
        prod_y_reg <= prod_y_next;
        cr_d1_reg  <= cos_r;
        sr_d1_reg  <= sin_r;
    end

    // Round back to Q16.16
    logic signed [65:0]   rnd_x;
    logic signed [65:0]   rnd_y;
    logic signed [CW-1:0] px_next;
    logic signed [CW-1:0] py_next;
    logic signed [CW-1:0] px_reg;
    logic signed [CW-1:0] py_reg;
    logic signed [CW-1:0] cr_d2_reg;
    logic signed [CW-1:0] sr_d2_reg;

    assign rnd_x   = prod_x_reg + RND_66;
    assign rnd_y   = prod_y_reg + RND_66;
    assign px_next = $signed(rnd_x[CW+29:30]);
    assign py_next = $signed(rnd_y[CW+29:30]);

    always_ff @(posedge clk)
    begin
        px_reg    <= px_next;
        py_reg    <= py_next;
        cr_d2_reg <= cr_d1_reg;
        sr_d2_reg <= sr_d1_reg;
    end

    // Rotation products
    logic signed [67:0] pxc_reg;
    logic signed [67:0] pys_reg;
    logic signed [67:0] pxs_reg;
    logic signed [67:0] pyc_reg;
    logic signed [67:0] pxc_next;
    logic signed [67:0] pys_next;
    logic signed [67:0] pxs_next;
    logic signed [67:0] pyc_next;

    assign pxc_next = px_reg * cr_d2_reg;
    assign pys_next = py_reg * sr_d2_reg;
    assign pxs_next = px_reg * sr_d2_reg;
    assign pyc_next = py_reg * cr_d2_reg;

    always_ff @(posedge clk)
    begin
        pxc_reg <= pxc_next;
        pys_reg <= pys_next;
        pxs_reg <= pxs_next;
        pyc_reg <= pyc_next;
    end

    // Combine and round the rotated pair
    logic signed [68:0] sum_x;
    logic signed [68:0] sum_y;
    logic signed [35:0] xr_next;
    logic signed [35:0] yr_next;
    logic signed [35:0] xr_reg;
    logic signed [35:0] yr_reg;

    assign sum_x   = 69'(pxc_reg) - 69'(pys_reg) + RND_69;
    assign sum_y   = 69'(pxs_reg) + 69'(pyc_reg) + RND_69;
    assign xr_next = $signed(sum_x[65:30]);
    assign yr_next = $signed(sum_y[65:30]);

    always_ff @(posedge clk)
    begin
        xr_reg <= xr_next;
        yr_reg <= yr_next;
    end

    // Add the center and saturate
    logic signed [36:0] tot_x;
    logic signed [36:0] tot_y;
    logic signed [31:0] point_x_next;
    logic signed [31:0] point_y_next;
    logic signed [31:0] point_x_reg;
    logic signed [31:0] point_y_reg;

    assign tot_x = 37'(center_x_reg) + 37'(xr_reg);
    assign tot_y = 37'(center_y_reg) + 37'(yr_reg);

    always_comb
    begin
        priority if (tot_x > SAT_MAX)
            point_x_next = SAT_MAX[31:0];
        else if (tot_x < SAT_MIN)
            point_x_next = SAT_MIN[31:0];
        else
            point_x_next = tot_x[31:0];

        priority if (tot_y > SAT_MAX)
            point_y_next = SAT_MAX[31:0];
        else if (tot_y < SAT_MIN)
            point_y_next = SAT_MIN[31:0];
        else
            point_y_next = tot_y[31:0];
    end

    always_ff @(posedge clk)
    begin
        point_x_reg <= point_x_next;
        point_y_reg <= point_y_next;
    end

    assign done    = vld_reg[LAT-1];
    assign point_x = point_x_reg;
    assign point_y = point_y_reg;

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps

module tb;

    localparam int unsigned STAGES       = rep_pkg::CORDIC_STAGES_DEF;
    localparam int unsigned ITERS        = (STAGES < rep_pkg::ATAN_ENTRIES) ?
                                           STAGES : rep_pkg::ATAN_ENTRIES;
    localparam int unsigned LATENCY      = ITERS + 6;
    localparam int unsigned RANDOM_ITEMS = 1530;

    // atan(2^-i) in units of 2^-32 turn
    localparam longint ATAN_TURN [24] = '{
        64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4,
        64'h028B0D43, 64'h0145D7E1, 64'h00A2F61E, 64'h00517C55,
        64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
        64'h00028BE6, 64'h000145F3, 64'h0000A2FA, 64'h0000517D,
        64'h000028BE, 64'h0000145F, 64'h00000A30, 64'h00000518,
        64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051
    };

    typedef enum logic [1:0] {QUAD_0, QUAD_1, QUAD_2, QUAD_3} quadrant_t;

    typedef struct {
        logic signed [31:0] x;
        logic signed [31:0] y;
    } point_t;

    logic                               clk;
    logic                               rst_n;
    logic                               start;
    logic                               busy;
    logic [15:0]                        angle;
    logic                               done;
    logic signed [31:0]                 point_x;
    logic signed [31:0]                 point_y;
    logic                               wr_en;
    logic [rep_pkg::WR_INDEX_W-1:0]     wr_index;
    logic [rep_pkg::WR_DATA_W-1:0]      wr_data;

    // Shadow copy of the ellipse registers
    longint      center_x_q;
    longint      center_y_q;
    longint      major_q;
    longint      minor_q;
    logic [15:0] rotation_q;

    point_t pending_points[$];
    int     errors;
    int     random_sent;

    rotated_ellipse_point #(
        .CORDIC_STAGES(STAGES)
    ) uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .angle    (angle),
        .done     (done),
        .point_x  (point_x),
        .point_y  (point_y),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data)
    );

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    // cos/sin in Q2.30 of a 16-bit turn fraction, rotation-mode CORDIC
    function automatic void turn_to_cos_sin(input logic [15:0] ang,
                                            output longint cos_q30,
                                            output longint sin_q30);
        longint vx;
        longint vy;
        longint vz;
        longint dx;
        longint dy;
        vx = longint'(rep_pkg::CORDIC_GAIN);
        vy = 0;
        vz = longint'({ang[13:0], 16'h0000});
        for (int i = 0; i < ITERS; i++)
        begin
            dx = vy >>> i;
            dy = vx >>> i;
            if (vz >= 0)
            begin
                vx = vx - dx;
                vy = vy + dy;
                vz = vz - ATAN_TURN[i];
            end
            else
            begin
                vx = vx + dx;
                vy = vy - dy;
                vz = vz + ATAN_TURN[i];
            end
        end
        // quadrant fold
        case (quadrant_t'(ang[15:14]))
            QUAD_0:
            begin
                cos_q30 = vx;
                sin_q30 = vy;
            end
            QUAD_1:
            begin
                cos_q30 = -vy;
                sin_q30 = vx;
            end
            QUAD_2:
            begin
                cos_q30 = -vx;
                sin_q30 = -vy;
            end
            default:
            begin
                cos_q30 = vy;
                sin_q30 = -vx;
            end
        endcase
    endfunction

    function automatic longint round_q30(input longint v);
        return (v + 64'sd536870912) >>> 30;
    endfunction

    function automatic logic signed [31:0] clamp32(input longint v);
        if (v > 64'sd2147483647)
            return 32'sh7FFFFFFF;
        if (v < -64'sd2147483648)
            return 32'sh80000000;
        return v[31:0];
    endfunction

    function automatic point_t ellipse_point(input logic [15:0] t);
        longint ct;
        longint st;
        longint cr;
        longint sr;
        longint px;
        longint py;
        longint xr;
        longint yr;
        point_t pt;
        turn_to_cos_sin(t, ct, st);
        turn_to_cos_sin(rotation_q, cr, sr);
        px = round_q30(major_q * ct);
        py = round_q30(minor_q * st);
        xr = round_q30(px * cr - py * sr);
        yr = round_q30(px * sr + py * cr);
        pt.x = clamp32(center_x_q + xr);
        pt.y = clamp32(center_y_q + yr);
        return pt;
    endfunction

    // Register write, shadow updated at the same edge
    task automatic write_reg(input logic [rep_pkg::WR_INDEX_W-1:0] idx,
                             input logic [31:0] data);
        @(negedge clk);
        wr_en    <= 1'b1;
        wr_index <= idx;
        wr_data  <= data;
        @(posedge clk);
        case (idx)
            rep_pkg::REG_CENTER_X:     center_x_q = longint'(signed'(data));
            rep_pkg::REG_CENTER_Y:     center_y_q = longint'(signed'(data));
            rep_pkg::REG_MAJOR_RADIUS: major_q    = longint'(data[30:0]);
            rep_pkg::REG_MINOR_RADIUS: minor_q    = longint'(data[30:0]);
            rep_pkg::REG_ROTATION:     rotation_q = data[15:0];
            default: ;
        endcase
        @(negedge clk);
        wr_en <= 1'b0;
    endtask

    task automatic write_ellipse(input logic [31:0] cx, input logic [31:0] cy,
                                 input logic [31:0] a, input logic [31:0] b,
                                 input logic [31:0] rot);
        write_reg(rep_pkg::REG_CENTER_X, cx);
        write_reg(rep_pkg::REG_CENTER_Y, cy);
        write_reg(rep_pkg::REG_MAJOR_RADIUS, a);
        write_reg(rep_pkg::REG_MINOR_RADIUS, b);
        write_reg(rep_pkg::REG_ROTATION, rot);
    endtask

    // One angle beat; start is left high so back-to-back beats need no gap
    task automatic send_angle(input logic [15:0] a);
        @(negedge clk);
        start <= 1'b1;
        angle <= a;
        do
            @(posedge clk);
        while (busy);
        pending_points.push_back(ellipse_point(a));
    endtask

    task automatic idle_cycles(input int n);
        repeat (n)
        begin
            @(negedge clk);
            start <= 1'b0;
        end
    endtask

    // Stop sending and wait for every outstanding point
    task automatic drain;
        @(negedge clk);
        start <= 1'b0;
        while (pending_points.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic [31:0] pick_center;
        case ($urandom_range(0, 7))
            0:       return 32'h7FFFFFFF;
            1:       return 32'h80000000;
            2:       return 32'h0;
            3, 4:    return $urandom;
            default: return $urandom_range(0, 32'h01FFFFFF) - 32'h01000000;
        endcase
    endfunction

    function automatic logic [31:0] pick_radius;
        case ($urandom_range(0, 7))
            0:       return {1'($urandom_range(0, 1)), 31'h7FFFFFFF};
            1:       return {1'($urandom_range(0, 1)), 31'h0};
            2, 3:    return $urandom;
            default: return $urandom_range(0, 32'h00FFFFFF);
        endcase
    endfunction

    function automatic logic [31:0] pick_rotation;
        logic [31:0] r;
        r = $urandom;
        case ($urandom_range(0, 5))
            0:       return {r[31:16], 16'hFFFF};
            1:       return {r[31:16], 16'h0000};
            2:       return {r[31:16], r[1:0], 14'h0};
            default: return r;
        endcase
    endfunction

    function automatic logic [15:0] pick_angle;
        logic [15:0] a;
        a = 16'($urandom);
        case ($urandom_range(0, 15))
            0:       return {a[15:14], 14'h0000};
            1:       return {a[15:14], 14'h3FFF};
            2:       return {a[15:14], 14'h0001};
            default: return a;
        endcase
    endfunction

    task automatic test_reset_defaults;
        send_angle(16'h0000);
        send_angle(16'h4000);
        send_angle(16'h8000);
        send_angle(16'hC000);
        send_angle(16'hFFFF);
        send_angle(16'h2000);
        drain;
    endtask

    task automatic test_saturation;
        // x clips high at t=0, y clips low at t=3/4 turn
        write_ellipse(32'h7FFFFFFF, 32'h80000000, 32'hFFFFFFFF, 32'h7FFFFFFF, 32'h0);
        send_angle(16'h0000);
        send_angle(16'h4000);
        send_angle(16'h8000);
        send_angle(16'hC000);
        drain;
    endtask

    task automatic test_zero_radius;
        write_ellipse(32'h00123456, 32'hFFEDCBA9, 32'h80000000, 32'h0, 32'h2000);
        send_angle(16'h1234);
        send_angle(16'hFFFF);
        drain;
    endtask

    task automatic test_rotation_extremes;
        write_ellipse(32'h0, 32'h0, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'hFFFF);
        send_angle(16'h0000);
        send_angle(16'h4000);
        drain;
        write_reg(rep_pkg::REG_ROTATION, 32'hFFFF8000);
        send_angle(16'h6000);
        send_angle(16'hA000);
        drain;
    endtask

    task automatic test_ignored_index;
        for (int i = rep_pkg::REG_ROTATION + 1; i < 2 ** rep_pkg::WR_INDEX_W; i++)
            write_reg(rep_pkg::WR_INDEX_W'(i), $urandom);
        send_angle(16'h1555);
        send_angle(16'hEAAA);
        drain;
    endtask

    // Random ellipses, bursts of random length with random gaps (no gaps in every fifth phase)
    task automatic test_random_points;
        int phase;
        int n;
        int burst;
        bit no_idle;
        phase = 0;
        while (random_sent < RANDOM_ITEMS)
        begin
            drain;
            write_ellipse(pick_center(), pick_center(), pick_radius(), pick_radius(),
                          pick_rotation());
            if ($urandom_range(0, 3) == 0)
                write_reg(rep_pkg::WR_INDEX_W'($urandom_range(rep_pkg::REG_ROTATION + 1,
                          2 ** rep_pkg::WR_INDEX_W - 1)), $urandom);
            no_idle = (phase % 5 == 2);
            n       = $urandom_range(20, 150);
            burst   = $urandom_range(1, 40);
            for (int k = 0; k < n && random_sent < RANDOM_ITEMS; k++)
            begin
                if (!no_idle && burst == 0)
                begin
                    idle_cycles(($urandom_range(0, 3) == 0) ? 1 : $urandom_range(1, 12));
                    burst = $urandom_range(1, 40);
                end
                send_angle(pick_angle());
                burst--;
                random_sent++;
            end
            phase++;
        end
        drain;
    endtask

    // Result check against the oldest predicted point
    always @(posedge clk)
    begin
        point_t want;
        if (rst_n && done)
        begin
            if (pending_points.size() == 0)
            begin
                $display("%0t: unexpected point x=%0d y=%0d", $time, point_x, point_y);
                errors++;
            end
            else
            begin
                want = pending_points.pop_front();
                if (point_x !== want.x)
                begin
                    $display("%0t: point_x expected %0d got %0d", $time, want.x, point_x);
                    errors++;
                end
                if (point_y !== want.y)
                begin
                    $display("%0t: point_y expected %0d got %0d", $time, want.y, point_y);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        rst_n       = 1'b0;
        start       = 1'b0;
        angle       = 16'h0;
        wr_en       = 1'b0;
        wr_index    = '0;
        wr_data     = '0;
        errors      = 0;
        random_sent = 0;
        center_x_q  = 0;
        center_y_q  = 0;
        major_q     = 131072;
        minor_q     = 65536;
        rotation_q  = 16'h0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_reset_defaults();
        test_saturation();
        test_zero_radius();
        test_rotation_extremes();
        test_ignored_index();
        test_random_points();

        // catch any stray beat after the last expected one
        repeat (LATENCY + 8) @(posedge clk);
        if (errors == 0 && pending_points.size() == 0)
            $display("rotated_ellipse_point verification clean");
        else
            $display("rotated_ellipse_point verification failed");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("rotated_ellipse_point verification failed");
        $finish;
    end

endmodule
